### src/selective_repeat_sender_window_macros.svh
// Assertion helpers for the selective-repeat sender window.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SRSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srsw: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SRSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srsw: next-cycle check failed");

`else

`define SRSW_ASSERT_NOW(label, ante, cons)
`define SRSW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/srsw_pkg.sv
package srsw_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned FuncW = 2;
  localparam int unsigned SeqW  = 3;
  localparam int unsigned CntW  = 3;

  // Event codes
  typedef enum logic [FuncW-1:0] {
    FuncSend    = 2'd0,
    FuncAck     = 2'd1,
    FuncTimeout = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word and read its payload slot
    logic execute;  // update the window and load the result register
  } srsw_cmd_t;

endpackage

### src/srsw_ctrl.sv
module srsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srsw_pkg::srsw_cmd_t cmd_o
);
  import srsw_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } state_e;

  state_e state_q;
  logic   take;

  // Take a word when empty, or when the held result leaves this cycle
  assign in_ready_o  = (state_q == StIdle) || ((state_q == StResp) && out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StResp);

  always_comb begin
    cmd_o.capture = take;
    cmd_o.execute = (state_q == StExec);
  end

  // Sequence capture, update and hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (take) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q <= StResp;
        end
        StResp: begin
          if (out_ready_i) begin
            state_q <= take ? StExec : StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

### src/srsw_datapath.sv
module srsw_datapath #(
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned SEQ_SPACE    = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srsw_pkg::srsw_cmd_t           cmd_i,
  input  srsw_pkg::func_e               func_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_i,
  input  logic [srsw_pkg::SeqW-1:0]     seq_num_i,
  input  logic                          checksum_ok_i,
  output logic                          accepted_o,
  output logic                          tx_valid_o,
  output logic [srsw_pkg::SeqW-1:0]     tx_seq_o,
  output logic [PAYLOAD_BITS-1:0]       tx_payload_o,
  output logic                          timer_start_o,
  output logic                          timer_stop_o,
  output logic [srsw_pkg::SeqW-1:0]     timer_seq_o,
  output logic [srsw_pkg::SeqW-1:0]     window_base_o,
  output logic                          window_full_o
);
  import srsw_pkg::*;

  localparam int unsigned IdxW  = $clog2(SEQ_SPACE);
  localparam int unsigned SpanW = IdxW + 1;
  localparam int unsigned ScanN = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;
  localparam int unsigned CmpW  = 9;

  // Distance from base to next around the sequence space
  function automatic logic [SpanW-1:0] span_of(input logic [IdxW-1:0] base,
                                                input logic [IdxW-1:0] nxt);
    logic [SpanW-1:0] span;
    if (nxt >= base) begin
      span = SpanW'(nxt) - SpanW'(base);
    end else begin
      span = SpanW'(nxt) + SpanW'(SEQ_SPACE) - SpanW'(base);
    end
    return span;
  endfunction

  // Slot index base + k, wrapped once
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] base,
                                               input int unsigned k);
    logic [SpanW-1:0] sum;
    sum = SpanW'(base) + SpanW'(k);
    if (sum >= SpanW'(SEQ_SPACE)) begin
      sum = sum - SpanW'(SEQ_SPACE);
    end
    return IdxW'(sum);
  endfunction

  // Window state
  logic [SEQ_SPACE-1:0] busy_q, busy_d;
  logic [IdxW-1:0]      base_q, base_d;
  logic [IdxW-1:0]      next_q, next_d;
  logic [CntW-1:0]      count_q, count_d;

  // Captured word and payload store
  logic [PAYLOAD_BITS-1:0] slot_mem [SEQ_SPACE];
  logic [PAYLOAD_BITS-1:0] rd_q;
  func_e                   func_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SeqW-1:0]         seq_q;
  logic                    ck_q;

  // Decode
  logic [IdxW-1:0]  seq_idx;
  logic [IdxW-1:0]  next_inc;
  logic [IdxW-1:0]  base_scan;
  logic [IdxW-1:0]  scan_idx;
  logic [SpanW-1:0] span_now;
  logic [SpanW-1:0] span_after;
  logic             in_space;
  logic             hit;
  logic             send_ok;
  logic             ack_ok;
  logic             tmo;
  logic             tmo_hit;
  logic             full_d;

  assign seq_idx  = IdxW'(seq_q);
  assign in_space = ({{(CmpW - SeqW){1'b0}}, seq_q} < CmpW'(SEQ_SPACE));
  assign hit      = in_space && busy_q[seq_idx];
  assign span_now = span_of(base_q, next_q);
  assign next_inc = (next_q == IdxW'(SEQ_SPACE - 1)) ? '0 : next_q + 1'b1;
  assign send_ok  = (func_q == FuncSend) &&
                    !((32'(span_now) >= 32'(WINDOW_SIZE)) || busy_q[next_q]);
  assign ack_ok   = (func_q == FuncAck) && ck_q;
  assign tmo      = (func_q == FuncTimeout);
  assign tmo_hit  = tmo && hit;

  // Mark, free and count slots
  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    next_d  = next_q;
    if (send_ok) begin
      busy_d[next_q] = 1'b1;
      count_d        = count_q + 1'b1;
      next_d         = next_inc;
    end
    if (ack_ok && hit) begin
      busy_d[seq_idx] = 1'b0;
      count_d         = count_q - 1'b1;
    end
  end

  // Find the oldest busy slot; busy slots only sit in the first window from base
  always_comb begin
    base_scan = next_q;
    scan_idx  = base_q;
    for (int k = ScanN - 1; k >= 0; k--) begin
      scan_idx = wrap_add(base_q, k);
      if (busy_d[scan_idx]) begin
        base_scan = scan_idx;
      end
    end
  end

  // Advance base
  always_comb begin
    base_d = base_q;
    if (send_ok && (count_q == '0)) begin
      base_d = next_q;
    end else if (ack_ok) begin
      base_d = base_scan;
    end
  end

  assign span_after = span_of(base_d, next_d);
  assign full_d     = (32'(span_after) >= 32'(WINDOW_SIZE)) || busy_d[next_d];

  // Hold window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      base_q  <= '0;
      next_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.execute) begin
      busy_q  <= busy_d;
      base_q  <= base_d;
      next_q  <= next_d;
      count_q <= count_d;
    end
  end

  // Latch the word and read its slot; store the payload of a new frame
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      pay_q  <= payload_i;
      seq_q  <= seq_num_i;
      ck_q   <= checksum_ok_i;
      rd_q   <= slot_mem[IdxW'(seq_num_i)];
    end
    if (cmd_i.execute && send_ok) begin
      slot_mem[next_q] <= pay_q;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      accepted_o    <= send_ok;
      tx_valid_o    <= send_ok || tmo_hit;
      tx_seq_o      <= send_ok ? SeqW'(next_q) : (tmo_hit ? seq_q : '0);
      tx_payload_o  <= send_ok ? pay_q : (tmo_hit ? rd_q : '0);
      timer_start_o <= send_ok || tmo;
      timer_stop_o  <= ack_ok;
      timer_seq_o   <= send_ok ? SeqW'(next_q) : ((tmo || ack_ok) ? seq_q : '0);
      window_base_o <= SeqW'(base_d);
      window_full_o <= full_d;
    end
  end

endmodule

### src/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window.
// Input channel (in_valid_i/in_ready_o) carries one event word: a send with
// its payload, an acknowledgement with its checksum flag, or a timer expiry,
// each naming a sequence number. Output channel (out_valid_o/out_ready_i)
// returns exactly one result word per event: frame to transmit, timer
// command, and window base and full status after the event.
// The event word is captured, the window is then updated in the execute
// state, and the result is offered in the response state after it.
// A new event is taken only once the previous result leaves; the execute
// state follows the registered read of the payload store, which a
// timeout needs before its retransmission can be formed.
// Reset clears the busy marks, base, next sequence number and count, so
// the window starts empty at zero. The payload store is not cleared; only
// busy slots are ever read back.
// While the receiver stalls, the result word is held unchanged and no new
// event is taken; the next event is taken in the cycle the result leaves.
`include "selective_repeat_sender_window_macros.svh"

module selective_repeat_sender_window #(
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned SEQ_SPACE    = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  srsw_pkg::func_e           func_i,
  input  logic [PAYLOAD_BITS-1:0]   payload_i,
  input  logic [srsw_pkg::SeqW-1:0] seq_num_i,
  input  logic                      checksum_ok_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic                      tx_valid_o,
  output logic [srsw_pkg::SeqW-1:0] tx_seq_o,
  output logic [PAYLOAD_BITS-1:0]   tx_payload_o,
  output logic                      timer_start_o,
  output logic                      timer_stop_o,
  output logic [srsw_pkg::SeqW-1:0] timer_seq_o,
  output logic [srsw_pkg::SeqW-1:0] window_base_o,
  output logic                      window_full_o
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;

  // Sequencer
  srsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Window bookkeeping and payload store
  srsw_datapath #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .payload_i     (payload_i),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .accepted_o    (accepted_o),
    .tx_valid_o    (tx_valid_o),
    .tx_seq_o      (tx_seq_o),
    .tx_payload_o  (tx_payload_o),
    .timer_start_o (timer_start_o),
    .timer_stop_o  (timer_stop_o),
    .timer_seq_o   (timer_seq_o),
    .window_base_o (window_base_o),
    .window_full_o (window_full_o)
  );

  // A taken word is never answered in the next cycle
  `SRSW_ASSERT_NEXT(a_no_early_result, cmd.capture, !out_valid_o)
  // An accepted send always transmits and starts its timer
  `SRSW_ASSERT_NOW(a_send_tx, out_valid_o && accepted_o, tx_valid_o && timer_start_o)
  // A new frame and its timer name the same sequence number
  `SRSW_ASSERT_NOW(a_send_seq, out_valid_o && accepted_o, tx_seq_o == timer_seq_o)
  // A timer stop comes alone
  `SRSW_ASSERT_NOW(a_stop_alone, out_valid_o && timer_stop_o,
                   !timer_start_o && !tx_valid_o && !accepted_o)

endmodule

### tb/sv/srsw_window_checker.sv
module srsw_window_checker
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // event channel
  input  logic                    ev_valid_i,
  input  logic                    ev_ready_i,
  input  func_e                   ev_func_i,
  input  logic [PAYLOAD_BITS-1:0] ev_payload_i,
  input  logic [SeqW-1:0]         ev_seq_i,
  input  logic                    ev_checksum_ok_i,
  // response channel
  input  logic                    res_valid_i,
  input  logic                    res_ready_i,
  input  logic                    res_accepted_i,
  input  logic                    res_tx_valid_i,
  input  logic [SeqW-1:0]         res_tx_seq_i,
  input  logic [PAYLOAD_BITS-1:0] res_tx_payload_i,
  input  logic                    res_timer_start_i,
  input  logic                    res_timer_stop_i,
  input  logic [SeqW-1:0]         res_timer_seq_i,
  input  logic [SeqW-1:0]         res_window_base_i,
  input  logic                    res_window_full_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SeqSpace = 2 ** SeqW;

  typedef struct packed {
    logic                    accepted;
    logic                    tx_valid;
    logic [SeqW-1:0]         tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic                    timer_start;
    logic                    timer_stop;
    logic [SeqW-1:0]         timer_seq;
    logic [SeqW-1:0]         window_base;
    logic                    window_full;
  } window_resp_t;

  // Shadow of the sender window
  logic                    slot_busy [SeqSpace];
  logic [PAYLOAD_BITS-1:0] slot_word [SeqSpace];
  logic [SeqW-1:0]         base_seq;
  logic [SeqW-1:0]         next_seq;
  logic [CntW-1:0]         live_count;

  window_resp_t response_q [$];

  // A send is refused once the window spans its full size or the next slot is taken
  function automatic logic window_closed();
    logic [SeqW-1:0] span;
    span = next_seq - base_seq;
    return (32'(span) >= WINDOW_SIZE) || slot_busy[next_seq];
  endfunction

  // Move base to the oldest busy slot, or to next_seq when none is busy
  function automatic void rebase();
    logic [SeqW-1:0] start;
    logic [SeqW-1:0] idx;
    logic            found;
    int unsigned     k;
    start = base_seq;
    found = 1'b0;
    for (k = 0; k < SeqSpace; k++) begin
      idx = start + SeqW'(k);
      if (!found && slot_busy[idx]) begin
        base_seq = idx;
        found    = 1'b1;
      end
    end
    if (!found) base_seq = next_seq;
  endfunction

  // Apply one event to the shadow window and form the response it produces
  function automatic window_resp_t apply_event(func_e f, logic [PAYLOAD_BITS-1:0] pay,
                                               logic [SeqW-1:0] seq, logic ck);
    window_resp_t r;
    r = '0;
    case (f)
      FuncSend: begin
        if (!window_closed()) begin
          slot_busy[next_seq] = 1'b1;
          slot_word[next_seq] = pay;
          live_count          = live_count + 1'b1;
          r.accepted          = 1'b1;
          r.tx_valid          = 1'b1;
          r.tx_seq            = next_seq;
          r.tx_payload        = pay;
          r.timer_start       = 1'b1;
          r.timer_seq         = next_seq;
          if (live_count == CntW'(1)) base_seq = next_seq;
          next_seq = next_seq + 1'b1;
        end
      end
      FuncAck: begin
        // a failed checksum drops the whole event
        if (ck) begin
          r.timer_stop = 1'b1;
          r.timer_seq  = seq;
          if (slot_busy[seq]) begin
            slot_busy[seq] = 1'b0;
            live_count     = live_count - 1'b1;
          end
          rebase();
        end
      end
      FuncTimeout: begin
        // restart the timer always, retransmit only a frame still outstanding
        r.timer_start = 1'b1;
        r.timer_seq   = seq;
        if (slot_busy[seq]) begin
          r.tx_valid   = 1'b1;
          r.tx_seq     = seq;
          r.tx_payload = slot_word[seq];
        end
      end
      default: ;
    endcase
    r.window_base = base_seq;
    r.window_full = window_closed();
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  // Compare each response word first, then record the event taken in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    window_resp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SeqSpace; i++) slot_busy[i] = 1'b0;
      base_seq     = '0;
      next_seq     = '0;
      live_count   = '0;
      fail_count_o = 0;
      response_q.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (response_q.size() == 0) begin
          $display("%0t: unexpected response word, expected none, got base %0h tx %0b",
                   $time, res_window_base_i, res_tx_valid_i);
          fail_count_o++;
        end else begin
          want = response_q.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(res_accepted_i));
          check_field("tx_valid", 64'(want.tx_valid), 64'(res_tx_valid_i));
          check_field("tx_seq", 64'(want.tx_seq), 64'(res_tx_seq_i));
          check_field("tx_payload", 64'(want.tx_payload), 64'(res_tx_payload_i));
          check_field("timer_start", 64'(want.timer_start), 64'(res_timer_start_i));
          check_field("timer_stop", 64'(want.timer_stop), 64'(res_timer_stop_i));
          check_field("timer_seq", 64'(want.timer_seq), 64'(res_timer_seq_i));
          check_field("window_base", 64'(want.window_base), 64'(res_window_base_i));
          check_field("window_full", 64'(want.window_full), 64'(res_window_full_i));
        end
      end
      if (ev_valid_i && ev_ready_i) begin
        response_q.insert(response_q.size(),
                          apply_event(ev_func_i, ev_payload_i, ev_seq_i,
                                      ev_checksum_ok_i));
      end
      pending_o <= response_q.size();
    end
  end

endmodule

### tb/sv/selective_repeat_sender_window_tb.sv
module selective_repeat_sender_window_tb;

  import srsw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAYLOAD_BITS = 64;
  localparam int unsigned RandomEvents = 1625;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 8;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  func_e                   func_i;
  logic [PAYLOAD_BITS-1:0] payload_i;
  logic [SeqW-1:0]         seq_num_i;
  logic                    checksum_ok_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    accepted_o;
  logic                    tx_valid_o;
  logic [SeqW-1:0]         tx_seq_o;
  logic [PAYLOAD_BITS-1:0] tx_payload_o;
  logic                    timer_start_o;
  logic                    timer_stop_o;
  logic [SeqW-1:0]         timer_seq_o;
  logic [SeqW-1:0]         window_base_o;
  logic                    window_full_o;

  int unsigned pending;
  int unsigned fail_count;
  logic        steady_send;
  logic        steady_drain;
  logic [7:0]  seq_in_flight;

  selective_repeat_sender_window dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .payload_i     (payload_i),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .tx_valid_o    (tx_valid_o),
    .tx_seq_o      (tx_seq_o),
    .tx_payload_o  (tx_payload_o),
    .timer_start_o (timer_start_o),
    .timer_stop_o  (timer_stop_o),
    .timer_seq_o   (timer_seq_o),
    .window_base_o (window_base_o),
    .window_full_o (window_full_o)
  );

  srsw_window_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ev_valid_i        (in_valid_i),
    .ev_ready_i        (in_ready_o),
    .ev_func_i         (func_i),
    .ev_payload_i      (payload_i),
    .ev_seq_i          (seq_num_i),
    .ev_checksum_ok_i  (checksum_ok_i),
    .res_valid_i       (out_valid_o),
    .res_ready_i       (out_ready_i),
    .res_accepted_i    (accepted_o),
    .res_tx_valid_i    (tx_valid_o),
    .res_tx_seq_i      (tx_seq_o),
    .res_tx_payload_i  (tx_payload_o),
    .res_timer_start_i (timer_start_o),
    .res_timer_stop_i  (timer_stop_o),
    .res_timer_seq_i   (timer_seq_o),
    .res_window_base_i (window_base_o),
    .res_window_full_i (window_full_o),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Track which sequence numbers look outstanding, to aim acks and timeouts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_in_flight <= '0;
    end else if (out_valid_o && out_ready_i) begin
      if (accepted_o) seq_in_flight[tx_seq_o] <= 1'b1;
      if (timer_stop_o) seq_in_flight[timer_seq_o] <= 1'b0;
    end
  end

  function automatic logic [PAYLOAD_BITS-1:0] rnd_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly pick a frame believed outstanding, sometimes any sequence number
  function automatic logic [SeqW-1:0] pick_seq();
    logic [SeqW-1:0] start;
    logic [SeqW-1:0] idx;
    int unsigned     k;
    start = SeqW'($urandom_range(0, 7));
    if (seq_in_flight == '0 || $urandom_range(0, 99) < 25) return start;
    for (k = 0; k < 8; k++) begin
      idx = start + SeqW'(k);
      if (seq_in_flight[idx]) return idx;
    end
    return start;
  endfunction

  // Offer one event word after a random gap and hold it until taken
  task automatic drive_event(func_e f, logic [PAYLOAD_BITS-1:0] pay, logic [SeqW-1:0] seq,
                             logic ck);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    payload_i     <= pay;
    seq_num_i     <= seq;
    checksum_ok_i <= ck;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Response side: stall a random number of cycles before each word
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ready_i  = 1'b0;
    steady_drain = 1'b0;
    taken        = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) steady_drain = ($urandom_range(0, 3) == 0);
      stall = steady_drain ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      taken++;
    end
  end

  // Abort when no word moves on either channel for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned pick;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FuncNone;
    payload_i     = '0;
    seq_num_i     = '0;
    checksum_ok_i = 1'b0;
    steady_send   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // timeout and ack on an empty window
    drive_event(FuncTimeout, rnd_word(), 3'd0, 1'b1);
    drive_event(FuncAck, rnd_word(), 3'd0, 1'b1);
    // fill the window with extreme payloads, then get refused
    drive_event(FuncSend, 64'h0, 3'd5, 1'b0);
    drive_event(FuncSend, '1, 3'd2, 1'b1);
    drive_event(FuncSend, 64'hAAAA_AAAA_AAAA_AAAA, 3'd7, 1'b0);
    drive_event(FuncSend, 64'h5555_5555_5555_5555, 3'd1, 1'b1);
    drive_event(FuncSend, 64'h1, 3'd0, 1'b1);
    // bad checksum, then out-of-order ack that leaves base in place
    drive_event(FuncAck, rnd_word(), 3'd1, 1'b0);
    drive_event(FuncAck, rnd_word(), 3'd1, 1'b1);
    drive_event(FuncTimeout, rnd_word(), 3'd1, 1'b0);
    drive_event(FuncTimeout, rnd_word(), 3'd2, 1'b0);
    drive_event(FuncAck, rnd_word(), 3'd0, 1'b1);
    drive_event(FuncNone, rnd_word(), 3'd7, 1'b1);
    drive_event(FuncSend, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
    drive_event(FuncSend, rnd_word(), 3'd0, 1'b0);
    drive_event(FuncSend, rnd_word(), 3'd0, 1'b0);
    // drain the window completely
    drive_event(FuncAck, rnd_word(), 3'd2, 1'b1);
    drive_event(FuncAck, rnd_word(), 3'd3, 1'b1);
    drive_event(FuncAck, rnd_word(), 3'd4, 1'b1);
    drive_event(FuncAck, rnd_word(), 3'd5, 1'b1);
    // wrap the sequence space
    drive_event(FuncSend, rnd_word(), 3'd0, 1'b0);
    drive_event(FuncSend, rnd_word(), 3'd0, 1'b0);
    drive_event(FuncSend, rnd_word(), 3'd0, 1'b0);
    drive_event(FuncAck, rnd_word(), 3'd7, 1'b1);
    drive_event(FuncTimeout, rnd_word(), 3'd6, 1'b1);
    hold_until_drained();

    // Random traffic, mostly aimed at live frames
    for (int unsigned i = 0; i < RandomEvents; i++) begin
      if (i % 125 == 0) steady_send = ($urandom_range(0, 3) == 0);
      if (i % 400 == 200) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        drive_event(FuncSend, rnd_word(), SeqW'($urandom_range(0, 7)), 1'($urandom));
      end else if (pick < 70) begin
        drive_event(FuncAck, rnd_word(), pick_seq(), $urandom_range(0, 99) < 85);
      end else if (pick < 92) begin
        drive_event(FuncTimeout, rnd_word(), pick_seq(), 1'($urandom));
      end else begin
        drive_event(FuncNone, rnd_word(), SeqW'($urandom_range(0, 7)), 1'($urandom));
      end
    end

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
